### rtl/stn_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and the signature marker for the script text normalizer.
package stn_pkg;

  localparam int UNIT_W       = 16;
  localparam int STOP_LEN_DEF = 34;
  localparam int SIG_LEN      = 34;

  typedef logic [UNIT_W-1:0] unit_t;

  localparam unit_t CH_LF     = 16'h000A;
  localparam unit_t CH_SPACE  = 16'h0020;
  localparam unit_t CH_DQUOTE = 16'h0022;
  localparam unit_t CH_SQUOTE = 16'h0027;
  localparam unit_t CH_STAR   = 16'h002A;
  localparam unit_t CH_SLASH  = 16'h002F;
  localparam unit_t CH_BSLASH = 16'h005C;

  // "\r\n/* SIG # Begin signature block\r\n"
  localparam unit_t SIG_MARKER [SIG_LEN] = '{
    16'h000D, 16'h000A, 16'h002F, 16'h002A, 16'h0020, 16'h0053, 16'h0049,
    16'h0047, 16'h0020, 16'h0023, 16'h0020, 16'h0042, 16'h0065, 16'h0067,
    16'h0069, 16'h006E, 16'h0020, 16'h0073, 16'h0069, 16'h0067, 16'h006E,
    16'h0061, 16'h0074, 16'h0075, 16'h0072, 16'h0065, 16'h0020, 16'h0062,
    16'h006C, 16'h006F, 16'h0063, 16'h006B, 16'h000D, 16'h000A
  };

  typedef struct packed {
    unit_t code_unit;
    logic  end_of_text;
  } item_t;

  typedef struct packed {
    unit_t out_unit;
    logic  unit_valid;
    logic  final_unit;
  } result_t;

  typedef struct packed {
    logic take_in;
    logic drain_load;
    logic drain_step;
    logic flush;
    logic release_hold;
    logic release_final;
    logic term;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic pend_empty;
    logic hold_valid;
    logic out_free;
    logic produced;
    logic match;
    logic drain_done;
  } status_t;

endpackage

### rtl/stn_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the script text normalizer.
module stn_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  logic            last_item,
  input  stn_pkg::status_t sts,
  output logic            item_stall,
  output stn_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DRAIN,
    S_FLUSH,
    S_TERM
  } state_t;

  state_t state;
  state_t state_next;
  logic   term_done;

  assign item_stall = !((state == S_IDLE) && sts.pend_empty);

  // The closing word is out once the last held word (or the empty terminator) leaves.
  assign term_done = sts.pend_empty && sts.out_free &&
                     (sts.produced ? sts.hold_valid : !sts.hold_valid);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.release_hold = 1'b1;
        if (item_valid && sts.pend_empty) begin
          cmd.take_in = 1'b1;
          if (last_item) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd.drain_load = 1'b1;
        state_next     = sts.match ? S_FLUSH : S_DRAIN;
      end
      S_DRAIN: begin
        if (sts.drain_done) begin
          state_next = S_FLUSH;
        end else if (sts.pend_empty) begin
          cmd.drain_step = 1'b1;
        end
      end
      S_FLUSH: begin
        if (sts.pend_empty) begin
          cmd.flush  = 1'b1;
          state_next = S_TERM;
        end
      end
      S_TERM: begin
        if (sts.pend_empty) begin
          cmd.release_hold  = sts.hold_valid;
          cmd.release_final = sts.produced;
          cmd.term          = !sts.produced && !sts.hold_valid;
        end
        if (term_done) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/stn_datapath.sv
`timescale 1ns / 1ps
// Datapath of the script text normalizer: tail window, scanner state and word output.
module stn_datapath #(
  parameter int STOP_LEN = stn_pkg::STOP_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  stn_pkg::item_t    item,
  input  stn_pkg::cmd_t     cmd,
  output stn_pkg::status_t  sts,
  output logic              result_valid,
  input  logic              result_stall,
  output stn_pkg::result_t  result
);

  localparam int FILL_W = $clog2(STOP_LEN + 1);

  typedef enum logic [1:0] {QM_NONE, QM_DOUBLE, QM_SINGLE} quote_t;
  typedef enum logic [1:0] {CM_NONE, CM_LINE, CM_BLOCK} comment_t;

  typedef struct packed {
    quote_t   quote_mode;
    logic     after_backslash;
    comment_t comment_mode;
    logic     star_seen;
    logic     slash_held;
    logic     in_blank_run;
    logic     space_held;
  } norm_t;

  // mask bit 0: space, bit 1: slash, bit 2: the unit itself
  typedef struct packed {
    norm_t      st;
    logic [2:0] mask;
  } step_t;

  function automatic step_t norm_step(norm_t s, stn_pkg::unit_t c);
    step_t r;
    logic  escaped;
    logic  done;
    logic  held;
    logic  graphic;
    logic  blank;
    r       = '{st: s, mask: 3'b000};
    done    = 1'b0;
    held    = 1'b0;
    escaped = 1'b0;
    graphic = (c inside {[16'h0021:16'h007E]}) || (c >= 16'h0080);
    blank   = c inside {[16'h0009:16'h000D], stn_pkg::CH_SPACE};
    case (s.comment_mode)
      CM_LINE: begin
        if (c == stn_pkg::CH_LF) begin
          r.st.comment_mode = CM_NONE;
          if (!s.in_blank_run) begin
            r.st.in_blank_run = 1'b1;
            r.st.space_held   = 1'b1;
          end
        end
      end
      CM_BLOCK: begin
        if (s.star_seen && c == stn_pkg::CH_SLASH) begin
          r.st.comment_mode = CM_NONE;
          r.st.star_seen    = 1'b0;
        end else begin
          r.st.star_seen = (c == stn_pkg::CH_STAR);
        end
      end
      default: begin
        if (s.slash_held) begin
          r.st.slash_held = 1'b0;
          if (c == stn_pkg::CH_SLASH) begin
            r.st.comment_mode    = CM_LINE;
            r.st.after_backslash = 1'b0;
            done                 = 1'b1;
          end else if (c == stn_pkg::CH_STAR) begin
            r.st.comment_mode    = CM_BLOCK;
            r.st.star_seen       = 1'b0;
            r.st.after_backslash = 1'b0;
            done                 = 1'b1;
          end else begin
            r.mask[0]         = r.st.space_held;
            r.st.space_held   = 1'b0;
            r.mask[1]         = 1'b1;
            r.st.in_blank_run = 1'b0;
          end
        end
        if (!done) begin
          escaped              = r.st.after_backslash;
          r.st.after_backslash = !escaped && (c == stn_pkg::CH_BSLASH);
          if (r.st.quote_mode == QM_NONE) begin
            if (c == stn_pkg::CH_SLASH) begin
              r.st.slash_held = 1'b1;
              held            = 1'b1;
            end else if (!escaped && c == stn_pkg::CH_DQUOTE) begin
              r.st.quote_mode = QM_DOUBLE;
            end else if (!escaped && c == stn_pkg::CH_SQUOTE) begin
              r.st.quote_mode = QM_SINGLE;
            end
          end else if (!escaped &&
                       ((r.st.quote_mode == QM_DOUBLE && c == stn_pkg::CH_DQUOTE) ||
                        (r.st.quote_mode == QM_SINGLE && c == stn_pkg::CH_SQUOTE))) begin
            r.st.quote_mode = QM_NONE;
          end
          if (!held) begin
            if (graphic) begin
              if (r.st.space_held) begin
                r.mask[0]       = 1'b1;
                r.st.space_held = 1'b0;
              end
              r.mask[2]         = 1'b1;
              r.st.in_blank_run = 1'b0;
            end else if (blank && !r.st.in_blank_run) begin
              r.st.in_blank_run = 1'b1;
              r.st.space_held   = 1'b1;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  stn_pkg::unit_t   taps [STOP_LEN];
  logic [FILL_W-1:0] window_fill;
  logic [FILL_W-1:0] drain_left;
  norm_t            norm;
  logic [2:0]       pend;
  stn_pkg::unit_t   pend_unit;
  logic             hold_valid;
  stn_pkg::unit_t   hold_unit;
  logic             produced;
  stn_pkg::result_t out_word;
  logic             out_valid;

  logic             window_full;
  logic             match;
  step_t            step;
  logic [2:0]       pend_low;
  stn_pkg::unit_t   pend_word;
  logic             out_free;
  logic             move_pend;
  logic             do_release;
  logic             do_term;
  logic             drain_use;
  logic [2:0]       flush_mask;

  assign window_full = (window_fill == FILL_W'(STOP_LEN));
  assign step        = norm_step(norm, taps[0]);
  assign drain_use   = (drain_left <= window_fill);

  generate
    if (STOP_LEN == stn_pkg::SIG_LEN) begin : g_marker
      logic [STOP_LEN-1:0] tap_eq;
      for (genvar k = 0; k < STOP_LEN; k++) begin : g_eq
        assign tap_eq[k] = (taps[k] == stn_pkg::SIG_MARKER[k]);
      end
      assign match = window_full && (&tap_eq);
    end else begin : g_no_marker
      assign match = 1'b0;
    end
  endgenerate

  always_comb begin
    flush_mask = 3'b000;
    if (norm.slash_held) begin
      flush_mask = {1'b0, 1'b1, norm.space_held};
    end else if (norm.space_held && norm.quote_mode != QM_NONE) begin
      flush_mask = 3'b001;
    end
  end

  assign pend_low  = pend & (~pend + 3'b001);
  assign pend_word = pend[0] ? stn_pkg::CH_SPACE :
                     (pend[1] ? stn_pkg::CH_SLASH : pend_unit);
  assign out_free   = !out_valid || !result_stall;
  assign move_pend  = (|pend) && (!hold_valid || out_free);
  assign do_release = !move_pend && cmd.release_hold && hold_valid && out_free;
  assign do_term    = cmd.term && out_free && !hold_valid && !(|pend);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill <= '0;
      drain_left  <= '0;
      norm        <= '0;
      pend        <= '0;
      hold_valid  <= 1'b0;
      produced    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // word output: pending words pass through a one-word hold so that the
      // final flag can be put on the last word of a text
      if (move_pend) begin
        pend       <= pend & ~pend_low;
        hold_unit  <= pend_word;
        hold_valid <= 1'b1;
        produced   <= 1'b1;
        if (hold_valid) begin
          out_word  <= '{out_unit: hold_unit, unit_valid: 1'b1, final_unit: 1'b0};
          out_valid <= 1'b1;
        end else if (!result_stall) begin
          out_valid <= 1'b0;
        end
      end else if (do_release) begin
        hold_valid <= 1'b0;
        out_word   <= '{out_unit: hold_unit, unit_valid: 1'b1,
                        final_unit: cmd.release_final};
        out_valid  <= 1'b1;
      end else if (do_term) begin
        out_word  <= '{out_unit: '0, unit_valid: 1'b0, final_unit: 1'b1};
        out_valid <= 1'b1;
      end else if (!result_stall) begin
        out_valid <= 1'b0;
      end

      if (cmd.take_in) begin
        produced <= 1'b0;
        if (window_full) begin
          norm      <= step.st;
          pend      <= step.mask;
          pend_unit <= taps[0];
        end else begin
          window_fill <= window_fill + FILL_W'(1);
        end
      end
      if (cmd.drain_load) begin
        drain_left <= FILL_W'(STOP_LEN);
      end
      if (cmd.drain_step) begin
        drain_left <= drain_left - FILL_W'(1);
        if (drain_use) begin
          norm      <= step.st;
          pend      <= step.mask;
          pend_unit <= taps[0];
        end
      end
      if (cmd.flush) begin
        pend <= flush_mask;
      end
      if (cmd.clear) begin
        norm        <= '0;
        window_fill <= '0;
        produced    <= 1'b0;
      end
    end
  end

  // Tail window as a shift line: the newest unit enters at the top, the oldest leaves at tap 0.
  always_ff @(posedge clk) begin
    if (cmd.take_in || cmd.drain_step) begin
      for (int i = 0; i < STOP_LEN - 1; i++) begin
        taps[i] <= taps[i+1];
      end
      taps[STOP_LEN-1] <= cmd.take_in ? item.code_unit : '0;
    end
  end

  assign result_valid = out_valid;
  assign result       = out_word;

  assign sts.pend_empty = !(|pend);
  assign sts.hold_valid = hold_valid;
  assign sts.out_free   = out_free;
  assign sts.produced   = produced;
  assign sts.match      = match;
  assign sts.drain_done = (drain_left == '0);

endmodule

### rtl/script_text_normalizer_unit.sv
`timescale 1ns / 1ps
// Top level of the script text normalizer: controller plus datapath.
//
//   channel   direction  handshake                payload
//   item      in         item_valid / item_stall  stn_pkg::item_t   (code_unit, end_of_text)
//   result    out        result_valid / result_stall  stn_pkg::result_t (out_unit, unit_valid,
//                                                                       final_unit)
//
// The scanner takes the next unit only after the pending words of the last one have moved
// on. The last item of a text adds the window drain, which shifts the STOP_LEN window
// places through the scanner and is skipped when the window holds the signature marker,
// then the flush of a held slash or quoted trailing space and the closing word. Reset
// (rst, synchronous) empties the window and returns the scanner to outside quotes and
// comments. A stalled result word holds; words wait in a one-word hold and the output
// register, and the scanner stops when both are full.

module script_text_normalizer_unit #(
  parameter int STOP_LEN = stn_pkg::STOP_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  stn_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output stn_pkg::result_t result
);

  // Commands from the controller and status back from the datapath.
  stn_pkg::cmd_t    cmd;
  stn_pkg::status_t sts;

  // The controller sequences the accept, marker check, window drain, flush of a
  // held slash or quoted trailing space, and the closing word of each text.
  stn_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .last_item  (item.end_of_text),
    .sts        (sts),
    .item_stall (item_stall),
    .cmd        (cmd)
  );

  // The datapath holds the tail window, the comment and quote scanner and the
  // word output path.
  stn_datapath #(
    .STOP_LEN (STOP_LEN)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### rtl/stn_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the script text normalizer and its bind to the top level.
module stn_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input stn_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input stn_pkg::result_t result
);

  // Only a space or a graphic unit is ever released as a character.
  a_char_class: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.unit_valid) |->
      (result.out_unit == 16'h0020) ||
      (result.out_unit >= 16'h0021 && result.out_unit <= 16'h007E) ||
      (result.out_unit >= 16'h0080))
    else $error("character word outside space and graphic units");

  // An empty terminator is zero and always closes the text.
  a_terminator: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.unit_valid) |->
      (result.out_unit == 16'h0000) && result.final_unit)
    else $error("malformed empty terminator");

  // The end of a text always starts the drain, so the next item must wait.
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.end_of_text) |=> item_stall)
    else $error("item taken right after end of text");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result word changed");

endmodule

bind script_text_normalizer_unit stn_checker u_stn_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

### bench/script_text_normalizer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the script text normalizer: word-level predictor, checker and stimulus.
package stn_bench_pkg;

  localparam stn_pkg::unit_t BLANK_LO     = 16'h0009;
  localparam stn_pkg::unit_t BLANK_HI     = 16'h000D;
  localparam stn_pkg::unit_t GRAPHIC_LO   = 16'h0021;
  localparam stn_pkg::unit_t GRAPHIC_HI   = 16'h007E;
  localparam stn_pkg::unit_t NON_ASCII_LO = 16'h0080;
  localparam int             MAX_REPORTS  = 10;

  typedef enum logic [1:0] {QUOTE_NONE, QUOTE_DOUBLE, QUOTE_SINGLE} quote_state_e;
  typedef enum logic [1:0] {CMT_NONE, CMT_LINE, CMT_BLOCK} comment_state_e;

  // Predicts the normalized word stream and checks the words that come out in order.
  class norm_stream_checker;
    stn_pkg::result_t expected_words[$];
    int               errors;
    stn_pkg::unit_t   window_q[$];
    quote_state_e     quote_st;
    comment_state_e   comment_st;
    bit               escape_next;
    bit               star_seen;
    bit               slash_held;
    bit               in_blank_run;
    bit               space_held;

    function new();
      errors = 0;
      clear_text_state();
    endfunction

    function void clear_text_state();
      window_q.delete();
      quote_st     = QUOTE_NONE;
      comment_st   = CMT_NONE;
      escape_next  = 1'b0;
      star_seen    = 1'b0;
      slash_held   = 1'b0;
      in_blank_run = 1'b0;
      space_held   = 1'b0;
    endfunction

    function void push_word(stn_pkg::unit_t u, logic v);
      stn_pkg::result_t r;
      r.out_unit   = u;
      r.unit_valid = v;
      r.final_unit = 1'b0;
      expected_words.push_back(r);
    endfunction

    function void put_graphic(stn_pkg::unit_t c);
      if (space_held) begin
        push_word(stn_pkg::CH_SPACE, 1'b1);
        space_held = 1'b0;
      end
      push_word(c, 1'b1);
      in_blank_run = 1'b0;
    endfunction

    function void classify(stn_pkg::unit_t c);
      if ((c >= GRAPHIC_LO && c <= GRAPHIC_HI) || c >= NON_ASCII_LO) begin
        put_graphic(c);
      end else if ((c >= BLANK_LO && c <= BLANK_HI) || c == stn_pkg::CH_SPACE) begin
        if (!in_blank_run) begin
          in_blank_run = 1'b1;
          space_held   = 1'b1;
        end
      end
    endfunction

    // Runs one unit that leaves the window through the comment, quote and blank logic.
    function void scan_unit(stn_pkg::unit_t c);
      bit escaped;
      if (comment_st == CMT_LINE) begin
        if (c == stn_pkg::CH_LF) begin
          comment_st = CMT_NONE;
          classify(c);
        end
        return;
      end
      if (comment_st == CMT_BLOCK) begin
        if (star_seen && c == stn_pkg::CH_SLASH) begin
          comment_st = CMT_NONE;
          star_seen  = 1'b0;
        end else begin
          star_seen = (c == stn_pkg::CH_STAR);
        end
        return;
      end
      if (slash_held) begin
        slash_held = 1'b0;
        if (c == stn_pkg::CH_SLASH) begin
          comment_st  = CMT_LINE;
          escape_next = 1'b0;
          return;
        end
        if (c == stn_pkg::CH_STAR) begin
          comment_st  = CMT_BLOCK;
          star_seen   = 1'b0;
          escape_next = 1'b0;
          return;
        end
        put_graphic(stn_pkg::CH_SLASH);
      end
      escaped     = escape_next;
      escape_next = !escaped && c == stn_pkg::CH_BSLASH;
      if (quote_st == QUOTE_NONE) begin
        if (c == stn_pkg::CH_SLASH) begin
          slash_held = 1'b1;
          return;
        end
        if (!escaped && c == stn_pkg::CH_DQUOTE) quote_st = QUOTE_DOUBLE;
        else if (!escaped && c == stn_pkg::CH_SQUOTE) quote_st = QUOTE_SINGLE;
      end else if (!escaped && ((quote_st == QUOTE_DOUBLE && c == stn_pkg::CH_DQUOTE) ||
                                (quote_st == QUOTE_SINGLE && c == stn_pkg::CH_SQUOTE))) begin
        quote_st = QUOTE_NONE;
      end
      classify(c);
    endfunction

    // Called for every accepted input word; appends the words it releases.
    function void note_item(stn_pkg::item_t it);
      int               first;
      int               k;
      bit               marker_hit;
      stn_pkg::result_t last_word;
      first = expected_words.size();
      if (window_q.size() >= stn_pkg::STOP_LEN_DEF) scan_unit(window_q.pop_front());
      window_q.push_back(it.code_unit);
      if (it.end_of_text) begin
        marker_hit = (stn_pkg::STOP_LEN_DEF == stn_pkg::SIG_LEN) &&
                     (window_q.size() == stn_pkg::SIG_LEN);
        for (k = 0; k < window_q.size() && marker_hit; k++)
          if (window_q[k] != stn_pkg::SIG_MARKER[k]) marker_hit = 1'b0;
        if (!marker_hit)
          for (k = 0; k < window_q.size(); k++) scan_unit(window_q[k]);
        if (slash_held) put_graphic(stn_pkg::CH_SLASH);
        else if (space_held && quote_st != QUOTE_NONE) push_word(stn_pkg::CH_SPACE, 1'b1);
        if (expected_words.size() == first) push_word('0, 1'b0);
        last_word = expected_words.pop_back();
        last_word.final_unit = 1'b1;
        expected_words.push_back(last_word);
        clear_text_state();
      end
    endfunction

    function void check_result(stn_pkg::result_t got);
      stn_pkg::result_t want;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected word: unit %h valid %b final %b",
                   got.out_unit, got.unit_valid, got.final_unit);
        return;
      end
      want = expected_words.pop_front();
      if (got.out_unit !== want.out_unit || got.unit_valid !== want.unit_valid ||
          got.final_unit !== want.final_unit) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("word mismatch: expected unit %h valid %b final %b, %s %h valid %b final %b",
                   want.out_unit, want.unit_valid, want.final_unit, "got unit",
                   got.out_unit, got.unit_valid, got.final_unit);
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

endpackage

module script_text_normalizer_unit_tb;

  // The slowest legal run is a few hundred items' worth of words under 30% stall plus
  // one long receiver hold; this limit is several times that.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 120;
  localparam int TARGET_ITEMS = 280;
  localparam int CALM_ITEMS   = 100;

  typedef stn_pkg::unit_t text_t[$];

  logic             clk = 1'b0;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  stn_pkg::item_t   item;
  logic             result_valid;
  logic             result_stall;
  stn_pkg::result_t result;

  stn_bench_pkg::norm_stream_checker checker_sb;
  int idle_pct;
  bit hold_req;
  int cycle_count;
  int items_sent;

  script_text_normalizer_unit uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Every word accepted on the result side is checked against the oldest prediction.
  // Outputs are read at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) checker_sb.check_result(result);
  end

  // Receiver: stalls at random, or for one long counted stretch when the stimulus asks.
  // During the long hold the block's output and hold registers fill and it stalls its input.
  initial begin : result_side
    int hold_left;
    bit hold_taken;
    hold_left    = 0;
    hold_taken   = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        result_stall = 1'b1;
        hold_left--;
      end else begin
        result_stall = ($urandom_range(99) < idle_pct);
      end
    end
  end

  // A watchdog that ends a run that has hung.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Offers one word, with random idle cycles first, and waits for it to be taken.
  // Called at a falling edge and returns at a falling edge, so valid is set once per step.
  task automatic send_item(input stn_pkg::item_t it);
    while ($urandom_range(99) < idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    item       = it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    checker_sb.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Sends a whole text, flagging the last unit as the end of the text.
  task automatic send_text(input text_t txt);
    stn_pkg::item_t it;
    int             k;
    for (k = 0; k < txt.size(); k++) begin
      it.code_unit   = txt[k];
      it.end_of_text = (k == txt.size() - 1);
      send_item(it);
    end
  endtask

  // Drops valid and waits until every predicted word has been seen.
  task automatic wait_for_drain();
    item_valid = 1'b0;
    while (checker_sb.pending() != 0) @(negedge clk);
  endtask

  // A unit drawn with heavy weight on the characters that steer the scanner.
  function automatic stn_pkg::unit_t script_unit();
    case ($urandom_range(15))
      0, 1, 2, 3: return stn_pkg::unit_t'(16'h0061 + $urandom_range(25));
      4:          return stn_pkg::CH_SPACE;
      5:          return stn_pkg::unit_t'($urandom_range(stn_bench_pkg::BLANK_HI,
                                                         stn_bench_pkg::BLANK_LO));
      6, 15:      return stn_pkg::CH_SLASH;
      7:          return stn_pkg::CH_STAR;
      8:          return stn_pkg::CH_DQUOTE;
      9:          return stn_pkg::CH_SQUOTE;
      10:         return stn_pkg::CH_BSLASH;
      11:         return stn_pkg::CH_LF;
      12: begin
        // Control units: below the blanks, between blanks and space, and DEL.
        case ($urandom_range(2))
          0:       return stn_pkg::unit_t'($urandom_range(8));
          1:       return stn_pkg::unit_t'($urandom_range(31, 14));
          default: return 16'h007F;
        endcase
      end
      13:         return stn_pkg::unit_t'($urandom_range(16'hFFFF,
                                                         stn_bench_pkg::NON_ASCII_LO));
      default:    return stn_pkg::unit_t'($urandom_range(stn_bench_pkg::GRAPHIC_HI,
                                                         stn_bench_pkg::GRAPHIC_LO));
    endcase
  endfunction

  // Builds one random text: random script units, script fragments of comments, quotes and
  // blanks, or units that end in the signature marker (sometimes spoiled); a few are pure noise.
  function automatic text_t random_text();
    text_t          txt;
    int             kind;
    int             k;
    stn_pkg::unit_t q;
    kind = $urandom_range(99);
    if (kind < 35) begin
      repeat ($urandom_range(24, 1)) txt.push_back(script_unit());
    end else if (kind < 65) begin
      repeat ($urandom_range(12)) txt.push_back(script_unit());
      for (k = 0; k < stn_pkg::SIG_LEN; k++) txt.push_back(stn_pkg::SIG_MARKER[k]);
      case ($urandom_range(5))
        0:       txt[txt.size() - 1 - $urandom_range(stn_pkg::SIG_LEN - 1)] = script_unit();
        1:       txt.push_back(script_unit());
        2:       void'(txt.pop_back());
        default: ;
      endcase
    end else if (kind < 88) begin
      repeat ($urandom_range(4, 1)) begin
        case ($urandom_range(3))
          0: begin
            txt.push_back(stn_pkg::CH_SLASH);
            txt.push_back(stn_pkg::CH_SLASH);
            repeat ($urandom_range(4)) txt.push_back(script_unit());
            txt.push_back(stn_pkg::CH_LF);
          end
          1: begin
            txt.push_back(stn_pkg::CH_SLASH);
            txt.push_back(stn_pkg::CH_STAR);
            repeat ($urandom_range(4)) txt.push_back(script_unit());
            txt.push_back(stn_pkg::CH_STAR);
            txt.push_back(stn_pkg::CH_SLASH);
          end
          2: begin
            // A quoted string, with escaped quotes and backslashes mixed in.
            q = $urandom_range(1) ? stn_pkg::CH_DQUOTE : stn_pkg::CH_SQUOTE;
            txt.push_back(q);
            repeat ($urandom_range(5)) begin
              if ($urandom_range(3) == 0) txt.push_back(stn_pkg::CH_BSLASH);
              txt.push_back($urandom_range(1) ? q : script_unit());
            end
            if ($urandom_range(3) != 0) txt.push_back(q);
          end
          default: begin
            repeat ($urandom_range(4, 1))
              txt.push_back($urandom_range(1) ? stn_pkg::CH_SPACE :
                            stn_pkg::unit_t'($urandom_range(stn_bench_pkg::BLANK_HI, 0)));
          end
        endcase
        if ($urandom_range(1)) txt.push_back(stn_pkg::unit_t'(16'h0061 + $urandom_range(25)));
      end
    end else begin
      repeat ($urandom_range(8, 1)) txt.push_back(stn_pkg::unit_t'($urandom_range(16'hFFFF)));
    end
    return txt;
  endfunction

  initial begin : stimulus
    text_t txt;
    checker_sb = new();
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    hold_req   = 1'b0;
    idle_pct   = 30;
    items_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Line comment closed by a newline, which then counts as a blank before 'a'.
    txt = '{stn_pkg::CH_SLASH, stn_pkg::CH_SLASH, 16'h0078, stn_pkg::CH_LF, 16'h0061};
    send_text(txt);
    // Block comment where the slash right after the opening pair does not close it.
    txt = '{stn_pkg::CH_SLASH, stn_pkg::CH_STAR, stn_pkg::CH_SLASH, stn_pkg::CH_STAR,
            stn_pkg::CH_SLASH, 16'h0062};
    send_text(txt);
    // Escaped quote inside a double-quoted string; a blank run left pending inside
    // the quote at the end is kept as one space.
    txt = '{stn_pkg::CH_DQUOTE, stn_pkg::CH_BSLASH, stn_pkg::CH_DQUOTE, 16'h0009,
            stn_pkg::CH_SPACE};
    send_text(txt);
    // Single quotes, dropped control units, extreme code units and a slash held at the end.
    txt = '{stn_pkg::CH_SQUOTE, 16'h0078, stn_pkg::CH_SQUOTE, 16'h0001, 16'h0000, 16'hFFFF,
            16'h007F, stn_bench_pkg::NON_ASCII_LO, stn_pkg::CH_SLASH};
    send_text(txt);
    // A text that yields nothing, so only the empty terminator comes out.
    txt = '{16'h0007};
    send_text(txt);

    // The sender holds back until every word of the directed part has come.
    wait_for_drain();

    // A stretch with no idling on either side.
    idle_pct = 0;
    while (items_sent < CALM_ITEMS) begin
      txt = random_text();
      send_text(txt);
    end

    // The receiver now holds off for a long stretch while words keep being offered.
    hold_req = 1'b1;
    idle_pct = 30;
    while (items_sent < TARGET_ITEMS) begin
      txt = random_text();
      send_text(txt);
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (checker_sb.errors == 0 && checker_sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
